/* rtl/rtpdtmf_pkg.sv */
`timescale 1ns / 1ps

package rtpdtmf_pkg;

  localparam int DQ_DEPTH    = 16;
  localparam int DQ_IDX_W    = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;
  localparam int DQ_CNT_W    = $clog2(DQ_DEPTH + 1);
  localparam int END_REPEATS = 3;
  localparam int REP_W       = 3;
  localparam int TONE_FRAMES = 8;

  localparam int DESC_Q_DEPTH = 2;
  localparam int DESC_PTR_W   = 1;
  localparam int DESC_CNT_W   = 2;

  localparam logic [7:0] RTP_V2_BYTE     = 8'h80;
  localparam logic [6:0] EVENT_VOLUME    = 7'h0A;
  localparam logic [3:0] AUDIO_LAST_IDX  = 4'd11;
  localparam logic [3:0] EVENT_LAST_IDX  = 4'd15;
  localparam logic       KIND_AUDIO      = 1'b0;
  localparam logic       KIND_EVENT      = 1'b1;

  typedef enum logic [1:0] {
    MODE_DIGIT = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_START = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_AUDIO_PT    = 3'd0,
    CFG_EVENT_PT    = 3'd1,
    CFG_EVENT_EN    = 3'd2,
    CFG_SOURCE_ID   = 3'd3,
    CFG_TS_STEP     = 3'd4,
    CFG_START_SEQ   = 3'd5,
    CFG_START_TS    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [6:0]  audio_pt;
    logic [6:0]  event_pt;
    logic        event_enable;
    logic [31:0] source_id;
    logic [12:0] ts_step;
    logic [15:0] start_seq;
    logic [31:0] start_ts;
  } cfg_t;

  // one packet to be serialised
  typedef struct packed {
    logic        kind;
    logic        marker;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [3:0]  code;
    logic        end_flag;
    logic [15:0] duration;
  } pkt_desc_t;

  typedef struct packed {
    logic      push;
    pkt_desc_t desc;
  } desc_push_t;

endpackage

/* rtl/rtpdtmf_queue.sv */
`timescale 1ns / 1ps

module rtpdtmf_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  rtpdtmf_pkg::desc_push_t wr,
  output logic                    full,
  input  logic                    pop,
  output logic                    rd_valid,
  output rtpdtmf_pkg::pkt_desc_t  rd_desc
);

  rtpdtmf_pkg::pkt_desc_t mem [rtpdtmf_pkg::DESC_Q_DEPTH];
  logic [rtpdtmf_pkg::DESC_PTR_W-1:0] wr_ptr;
  logic [rtpdtmf_pkg::DESC_PTR_W-1:0] rd_ptr;
  logic [rtpdtmf_pkg::DESC_CNT_W-1:0] count;
  logic                               do_push;
  logic                               do_pop;

  assign full     = (count == rtpdtmf_pkg::DESC_CNT_W'(rtpdtmf_pkg::DESC_Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_desc  = mem[rd_ptr];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && rd_valid;

  function automatic logic [rtpdtmf_pkg::DESC_PTR_W-1:0] ptr_inc(
    input logic [rtpdtmf_pkg::DESC_PTR_W-1:0] p
  );
    if (p == rtpdtmf_pkg::DESC_PTR_W'(rtpdtmf_pkg::DESC_Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/rtpdtmf_front.sv */
`timescale 1ns / 1ps

module rtpdtmf_front (
  input  logic                    clk,
  input  logic                    rst,
  input  rtpdtmf_pkg::cfg_t       cfg,
  input  logic                    item_valid,
  input  logic                    q_full,
  input  logic [1:0]              mode,
  input  logic [7:0]              digit_char,
  input  logic                    audio_ready,
  output rtpdtmf_pkg::desc_push_t wr
);

  localparam int SUM_W = rtpdtmf_pkg::DQ_CNT_W + 1;

  logic [7:0] fifo_mem [rtpdtmf_pkg::DQ_DEPTH];

  logic [15:0]                       seq, seq_next;
  logic [31:0]                       stream_ts, stream_ts_next;
  logic                              marker_pending, marker_pending_next;
  logic [rtpdtmf_pkg::DQ_CNT_W-1:0]  count, count_next;
  logic [rtpdtmf_pkg::DQ_IDX_W-1:0]  head, head_next;
  logic                              active, active_next;
  logic [3:0]                        code, code_next;
  logic [15:0]                       dur, dur_next;
  logic [rtpdtmf_pkg::REP_W-1:0]     reps, reps_next;
  logic [31:0]                       evts, evts_next;

  logic                              accept;
  logic                              fifo_wr;
  logic [SUM_W-1:0]                  tail_sum;
  logic [SUM_W-1:0]                  tail_wrap;
  logic [rtpdtmf_pkg::DQ_IDX_W-1:0]  tail;
  logic [rtpdtmf_pkg::DQ_IDX_W-1:0]  head_inc;
  logic [15:0]                       tone;
  logic [4:0]                        mapped;
  logic                              ev_ok;
  logic [3:0]                        cur_code;
  logic [15:0]                       cur_dur;
  logic [rtpdtmf_pkg::REP_W-1:0]     cur_reps;
  logic [rtpdtmf_pkg::REP_W-1:0]     reps_inc;
  logic [31:0]                       cur_evts;
  logic                              end_flag;

  // returns {valid, event code}
  function automatic logic [4:0] map_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin          // '0'..'9'
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c == 8'h2A) return {1'b1, 4'd10};         // '*'
    if (c == 8'h23) return {1'b1, 4'd11};         // '#'
    if (c >= 8'h41 && c <= 8'h44) begin          // 'A'..'D'
      d = c - 8'h41 + 8'd12;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h64) begin          // 'a'..'d'
      d = c - 8'h61 + 8'd12;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  assign accept   = item_valid && !q_full;
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail_wrap = (tail_sum >= SUM_W'(rtpdtmf_pkg::DQ_DEPTH))
                   ? tail_sum - SUM_W'(rtpdtmf_pkg::DQ_DEPTH) : tail_sum;
  assign tail     = tail_wrap[rtpdtmf_pkg::DQ_IDX_W-1:0];
  assign head_inc = (head == rtpdtmf_pkg::DQ_IDX_W'(rtpdtmf_pkg::DQ_DEPTH - 1))
                  ? '0 : head + 1'b1;
  assign tone     = 16'(rtpdtmf_pkg::TONE_FRAMES) * {3'b000, cfg.ts_step};
  assign mapped   = map_digit(fifo_mem[head]);

  always_comb begin
    seq_next            = seq;
    stream_ts_next      = stream_ts;
    marker_pending_next = marker_pending;
    count_next          = count;
    head_next           = head;
    active_next         = active;
    code_next           = code;
    dur_next            = dur;
    reps_next           = reps;
    evts_next           = evts;
    fifo_wr             = 1'b0;
    ev_ok               = 1'b1;
    cur_code            = code;
    cur_dur             = dur;
    cur_reps            = reps;
    cur_evts            = evts;
    reps_inc            = reps + 1'b1;
    end_flag            = 1'b0;
    wr                  = '0;

    if (accept) begin
      unique case (rtpdtmf_pkg::mode_t'(mode))
        rtpdtmf_pkg::MODE_DIGIT: begin
          if (cfg.event_enable &&
              count < rtpdtmf_pkg::DQ_CNT_W'(rtpdtmf_pkg::DQ_DEPTH)) begin
            fifo_wr    = 1'b1;
            count_next = count + 1'b1;
          end
        end
        rtpdtmf_pkg::MODE_START: begin
          seq_next            = cfg.start_seq;
          stream_ts_next      = cfg.start_ts;
          marker_pending_next = 1'b1;
          count_next          = '0;
          head_next           = '0;
          active_next         = 1'b0;
        end
        rtpdtmf_pkg::MODE_TICK: begin
          if (active || count != '0) begin
            if (!active) begin
              // pop a digit and start a new event; bad characters are simply eaten
              ev_ok      = mapped[4];
              head_next  = head_inc;
              count_next = count - 1'b1;
              if (ev_ok) begin
                cur_code    = mapped[3:0];
                cur_dur     = '0;
                cur_reps    = '0;
                cur_evts    = stream_ts;
                active_next = 1'b1;
              end
            end
            if (ev_ok) begin
              end_flag          = (cur_dur >= tone);
              wr.push           = 1'b1;
              wr.desc.kind      = rtpdtmf_pkg::KIND_EVENT;
              wr.desc.marker    = (cur_dur == '0);
              wr.desc.pt        = cfg.event_pt;
              wr.desc.seq       = seq;
              wr.desc.ts        = cur_evts;
              wr.desc.code      = cur_code;
              wr.desc.end_flag  = end_flag;
              wr.desc.duration  = cur_dur;
              seq_next          = seq + 1'b1;
              code_next         = cur_code;
              evts_next         = cur_evts;
              dur_next          = cur_dur;
              reps_next         = cur_reps;
              reps_inc          = cur_reps + 1'b1;
              if (end_flag) begin
                reps_next = reps_inc;
                if (reps_inc >= rtpdtmf_pkg::REP_W'(rtpdtmf_pkg::END_REPEATS)) begin
                  active_next         = 1'b0;
                  stream_ts_next      = cur_evts + 32'(cur_dur) + 32'(cfg.ts_step);
                  marker_pending_next = 1'b1;
                end
              end else begin
                dur_next = cur_dur + 16'(cfg.ts_step);
              end
            end
          end else if (audio_ready) begin
            wr.push             = 1'b1;
            wr.desc.kind        = rtpdtmf_pkg::KIND_AUDIO;
            wr.desc.marker      = marker_pending;
            wr.desc.pt          = cfg.audio_pt;
            wr.desc.seq         = seq;
            wr.desc.ts          = stream_ts;
            seq_next            = seq + 1'b1;
            stream_ts_next      = stream_ts + 32'(cfg.ts_step);
            marker_pending_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_mem[tail] <= digit_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq            <= '0;
      stream_ts      <= '0;
      marker_pending <= 1'b1;
      count          <= '0;
      head           <= '0;
      active         <= 1'b0;
      code           <= '0;
      dur            <= '0;
      reps           <= '0;
      evts           <= '0;
    end else begin
      seq            <= seq_next;
      stream_ts      <= stream_ts_next;
      marker_pending <= marker_pending_next;
      count          <= count_next;
      head           <= head_next;
      active         <= active_next;
      code           <= code_next;
      dur            <= dur_next;
      reps           <= reps_next;
      evts           <= evts_next;
    end
  end

endmodule

/* rtl/rtpdtmf_back.sv */
`timescale 1ns / 1ps

module rtpdtmf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            source_id,
  input  logic                   q_valid,
  input  rtpdtmf_pkg::pkt_desc_t q_desc,
  output logic                   q_pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [7:0]             out_byte,
  output logic                   packet_kind,
  output logic                   last_byte
);

  logic [3:0] idx;
  logic       is_last;
  logic       take;

  function automatic logic [7:0] pick_byte(
    input rtpdtmf_pkg::pkt_desc_t d,
    input logic [31:0]            ssrc,
    input logic [3:0]             i
  );
    unique case (i)
      4'd0:  return rtpdtmf_pkg::RTP_V2_BYTE;
      4'd1:  return {d.marker, d.pt};
      4'd2:  return d.seq[15:8];
      4'd3:  return d.seq[7:0];
      4'd4:  return d.ts[31:24];
      4'd5:  return d.ts[23:16];
      4'd6:  return d.ts[15:8];
      4'd7:  return d.ts[7:0];
      4'd8:  return ssrc[31:24];
      4'd9:  return ssrc[23:16];
      4'd10: return ssrc[15:8];
      4'd11: return ssrc[7:0];
      4'd12: return {4'b0000, d.code};
      4'd13: return {d.end_flag, rtpdtmf_pkg::EVENT_VOLUME};
      4'd14: return d.duration[15:8];
      4'd15: return d.duration[7:0];
    endcase
  endfunction

  assign is_last = (q_desc.kind == rtpdtmf_pkg::KIND_EVENT)
                 ? (idx == rtpdtmf_pkg::EVENT_LAST_IDX)
                 : (idx == rtpdtmf_pkg::AUDIO_LAST_IDX);
  // output register free or being drained this cycle
  assign take    = !result_valid || !result_stall;
  assign q_pop   = take && q_valid && is_last;

  always_ff @(posedge clk) begin
    if (take && q_valid) begin
      out_byte    <= pick_byte(q_desc, source_id, idx);
      packet_kind <= q_desc.kind;
      last_byte   <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (take) begin
      result_valid <= q_valid;
      if (q_valid) begin
        idx <= is_last ? 4'd0 : idx + 1'b1;
      end
    end
  end

endmodule

/* rtl/rtp_dtmf_event_packet_sender.sv */
`timescale 1ns / 1ps
// packet timing: a tick's descriptor is registered into the packet queue, and its first
// byte is then registered into the output register when the serialiser is idle
// throughput: one byte per cycle while not stalled; the serialiser sends 12 bytes per
// audio packet, 16 per event packet; other items are taken while the queue has room
// reset: synchronous, clears sequence, timestamps, digit queue and event state,
// arms the marker and loads register defaults

module rtp_dtmf_event_packet_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  digit_char,
  input  logic        audio_ready,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic        packet_kind,
  output logic        last_byte
);

  rtpdtmf_pkg::cfg_t       cfg;
  rtpdtmf_pkg::desc_push_t wr;
  rtpdtmf_pkg::pkt_desc_t  q_desc;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;

  assign item_stall = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.audio_pt     <= 7'd0;
      cfg.event_pt     <= 7'd101;
      cfg.event_enable <= 1'b1;
      cfg.source_id    <= '0;
      cfg.ts_step      <= 13'd160;
      cfg.start_seq    <= '0;
      cfg.start_ts     <= '0;
    end else if (cfg_write) begin
      unique case (rtpdtmf_pkg::cfg_idx_t'(cfg_index))
        rtpdtmf_pkg::CFG_AUDIO_PT:  cfg.audio_pt     <= cfg_data[6:0];
        rtpdtmf_pkg::CFG_EVENT_PT:  cfg.event_pt     <= cfg_data[6:0];
        rtpdtmf_pkg::CFG_EVENT_EN:  cfg.event_enable <= cfg_data[0];
        rtpdtmf_pkg::CFG_SOURCE_ID: cfg.source_id    <= cfg_data;
        rtpdtmf_pkg::CFG_TS_STEP:   cfg.ts_step      <= cfg_data[12:0];
        rtpdtmf_pkg::CFG_START_SEQ: cfg.start_seq    <= cfg_data[15:0];
        rtpdtmf_pkg::CFG_START_TS:  cfg.start_ts     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rtpdtmf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .q_full      (q_full),
    .mode        (mode),
    .digit_char  (digit_char),
    .audio_ready (audio_ready),
    .wr          (wr)
  );

  rtpdtmf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_desc  (q_desc)
  );

  rtpdtmf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .source_id    (cfg.source_id),
    .q_valid      (q_valid),
    .q_desc       (q_desc),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .packet_kind  (packet_kind),
    .last_byte    (last_byte)
  );

endmodule
